/* rtl/afrp_pkg.sv */
// shared types and constants for the api receive frame parser
// no dependencies
`timescale 1ns / 1ps

package afrp_pkg;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] SUM_GOOD = 8'hFF;
	localparam logic [15:0] HEADER_BYTES = 16'd12;
	localparam logic [7:0] EXPECTED_TYPE_RESET = 8'h90;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd100;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TYPE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_SUM = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;
	localparam logic [1:0] ST_BAD_LEN = 2'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] payload_length;
		logic [7:0]  options;
		logic [15:0] source_address_16;
		logic [63:0] source_address_64;
		logic [15:0] payload_index;
		logic [7:0]  data_byte;
		logic        kind;
	} afrp_result_t;

endpackage

/* rtl/afrp_parser.sv */
// byte-wise frame parser: header capture, running checksum, result build
// depends on afrp_pkg
`timescale 1ns / 1ps

module afrp_parser
	import afrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_fire,
	input  logic [7:0]   in_byte,
	input  logic [7:0]   expected_type,
	input  logic [15:0]  max_payload,
	output logic         res_valid,
	output afrp_result_t res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TYPE,
		PH_BODY
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [15:0]  byte_count_q, byte_count_d;
	logic [15:0]  frame_length_q, frame_length_d;
	logic [7:0]   running_sum_q, running_sum_d;
	logic [63:0]  address_long_q, address_long_d;
	logic [15:0]  address_short_q, address_short_d;
	logic [7:0]   options_held_q, options_held_d;
	logic         type_ok_q, type_ok_d;

	logic [15:0]  full_length;
	logic [16:0]  length_limit;
	logic [7:0]   sum_with_byte;

	assign full_length = {frame_length_q[15:8], in_byte};
	assign length_limit = {1'b0, max_payload} + {1'b0, HEADER_BYTES};
	assign sum_with_byte = running_sum_q + in_byte;

	always_comb begin
		phase_d = phase_q;
		byte_count_d = byte_count_q;
		frame_length_d = frame_length_q;
		running_sum_d = running_sum_q;
		address_long_d = address_long_q;
		address_short_d = address_short_q;
		options_held_d = options_held_q;
		type_ok_d = type_ok_q;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			PH_HUNT: begin
				if (in_byte == START_BYTE) begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				frame_length_d = {in_byte, 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frame_length_d = full_length;
				if (full_length < HEADER_BYTES || {1'b0, full_length} > length_limit) begin
					phase_d = PH_HUNT;
					res_valid = 1'b1;
					res.kind = KIND_SUMMARY;
					res.status = ST_BAD_LEN;
				end else begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_ok_d = (in_byte == expected_type);
				running_sum_d = in_byte;
				address_long_d = '0;
				address_short_d = '0;
				options_held_d = '0;
				byte_count_d = 16'd1;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (byte_count_q >= frame_length_q) begin
					// checksum byte: frame summary
					phase_d = PH_HUNT;
					res_valid = 1'b1;
					res.kind = KIND_SUMMARY;
					res.payload_length = frame_length_q - HEADER_BYTES;
					if (!type_ok_q) begin
						res.status = ST_BAD_TYPE;
					end else begin
						res.source_address_64 = address_long_q;
						res.source_address_16 = address_short_q;
						res.options = options_held_q;
						res.status = (sum_with_byte == SUM_GOOD) ? ST_OK : ST_BAD_SUM;
					end
				end else begin
					running_sum_d = sum_with_byte;
					byte_count_d = byte_count_q + 16'd1;
					if (byte_count_q <= 16'd8) begin
						address_long_d = {address_long_q[55:0], in_byte};
					end else if (byte_count_q <= 16'd10) begin
						address_short_d = {address_short_q[7:0], in_byte};
					end else if (byte_count_q == 16'd11) begin
						options_held_d = in_byte;
					end else if (type_ok_q) begin
						res_valid = 1'b1;
						res.kind = KIND_PAYLOAD;
						res.data_byte = in_byte;
						res.payload_index = byte_count_q - HEADER_BYTES;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			byte_count_q <= '0;
			frame_length_q <= '0;
			running_sum_q <= '0;
			address_long_q <= '0;
			address_short_q <= '0;
			options_held_q <= '0;
			type_ok_q <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			byte_count_q <= byte_count_d;
			frame_length_q <= frame_length_d;
			running_sum_q <= running_sum_d;
			address_long_q <= address_long_d;
			address_short_q <= address_short_d;
			options_held_q <= options_held_d;
			type_ok_q <= type_ok_d;
		end
	end

endmodule

/* rtl/afrp_out_buf.sv */
// two-entry result buffer between the parser and the master side
// depends on afrp_pkg
`timescale 1ns / 1ps

module afrp_out_buf
	import afrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  afrp_result_t push_data,
	output logic         space,
	output logic         pop_valid,
	input  logic         pop_ready,
	output afrp_result_t pop_data
);

	afrp_result_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         pop;

	assign space = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/api_frame_receive_parser.sv */
// top level: configuration registers, stream ports and field packing
// depends on afrp_pkg, afrp_parser, afrp_out_buf
// a byte that yields a result has it written into the result buffer when accepted; m_axis shows it from there
// throughput: one byte per cycle; s_axis_tready falls only while both result slots are full
// each byte updates the parser state in the cycle it is accepted, one result at most per byte
// reset: asynchronous, clears parser state, empties the result buffer, config to reset values
`timescale 1ns / 1ps

module api_frame_receive_parser
	import afrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // rx_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// data_byte, payload_index, source_address_64, source_address_16, options,
	// payload_length, status, zero fill
	output logic [135:0]           m_axis_tdata,
	output logic                   m_axis_tuser,  // kind
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	logic [7:0]   expected_type_q;
	logic [15:0]  max_payload_q;
	logic         in_fire;
	logic         res_valid;
	afrp_result_t res;
	afrp_result_t out_res;
	logic         buf_space;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = buf_space;
	assign in_fire = s_axis_tvalid && buf_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= EXPECTED_TYPE_RESET;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_EXPECTED_TYPE) begin
				expected_type_q <= cfg_data[7:0];
			end else if (cfg_index == REG_MAX_PAYLOAD) begin
				max_payload_q <= cfg_data;
			end
		end
	end

	afrp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.in_byte       (s_axis_tdata),
		.expected_type (expected_type_q),
		.max_payload   (max_payload_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	afrp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && res_valid),
		.push_data (res),
		.space     (buf_space),
		.pop_valid (m_axis_tvalid),
		.pop_ready (m_axis_tready),
		.pop_data  (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {
		6'd0,
		out_res.status,
		out_res.payload_length,
		out_res.options,
		out_res.source_address_16,
		out_res.source_address_64,
		out_res.payload_index,
		out_res.data_byte
	};

endmodule
